/* rtl/core/dpa_pkg.sv */
package dpa_pkg;

  // Field widths fixed by the register map and the result format.
  localparam int RATE_W     = 10;
  localparam int DUTY_W     = 7;
  localparam int INTEG_W    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_RATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEIL   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_FLOOR  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_FLOOR  = 4'd3;

  // Register values after reset.
  localparam logic [RATE_W-1:0] RST_UPDATE_RATE = 10'd100;
  localparam logic [DUTY_W-1:0] RST_DUTY_CEIL   = 7'd98;
  localparam logic [DUTY_W-1:0] RST_DUTY_FLOOR  = 7'd2;

  // Fixed loop gains of the two channels.
  localparam int MAIN_KP = 7;
  localparam int MAIN_KI = 2;
  localparam int MAIN_KD = 2;
  localparam int TAIL_KP = 10;
  localparam int TAIL_KI = 3;
  localparam int TAIL_KD = 2;

  // Sequencer states shared by both lanes.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_CLAMP
  } dpa_state_e;

  // Control strobes from the sequencer to the lanes.
  typedef struct packed {
    logic start;
    logic div_step;
    logic sum_step;
    logic commit;
  } dpa_ctrl_t;

endpackage

/* rtl/core/dpa_if.sv */
// Error sample channel: one transaction per control tick.
interface dpa_in_if #(
  parameter int ERROR_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [ERROR_WIDTH-1:0] alt_error;
  logic signed [ERROR_WIDTH-1:0] yaw_error;

  modport source (output valid, output alt_error, output yaw_error, input ready);
  modport sink   (input valid, input alt_error, input yaw_error, output ready);
endinterface

// Duty result channel.
interface dpa_out_if;
  logic                        valid;
  logic                        ready;
  logic [dpa_pkg::DUTY_W-1:0]  main_duty;
  logic [dpa_pkg::DUTY_W-1:0]  tail_duty;

  modport source (output valid, output main_duty, output tail_duty, input ready);
  modport sink   (input valid, input main_duty, input tail_duty, output ready);
endinterface

// Configuration write channel.
interface dpa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dpa_pkg::CFG_IDX_W-1:0]   index;
  logic [dpa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/dual_pid_antiwindup.sv */
// A tick is taken only in the idle state and then passes the divide, sum and clamp states;
// the restoring divider in each lane produces one quotient bit per cycle. The next tick
// is taken once the clamp state has loaded the result into the output register.
// A finished result may wait in the output register while the next tick is taken.
// Reset (rst_ni low, asynchronous) clears both integrals and last errors, empties the
// output register and returns the registers to rate 100, max 98 and minimums 2.
module dual_pid_antiwindup #(
  parameter int ERROR_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dpa_cfg_if.sink      cfg_i,
  dpa_in_if.sink       in_i,
  dpa_out_if.source    out_o
);

  localparam int CntW = $clog2(ERROR_WIDTH);

  // Configuration registers.
  logic [dpa_pkg::RATE_W-1:0] rate_q;
  logic [dpa_pkg::DUTY_W-1:0] duty_ceil_q;
  logic [dpa_pkg::DUTY_W-1:0] main_min_q;
  logic [dpa_pkg::DUTY_W-1:0] tail_min_q;
  logic [dpa_pkg::RATE_W-1:0] rate_eff;

  dpa_pkg::dpa_state_e state_q, state_d;
  logic [CntW-1:0]     cnt_q;
  dpa_pkg::dpa_ctrl_t  ctrl;
  logic                in_acc;
  logic                out_load;

  logic                       out_valid_q;
  logic [dpa_pkg::DUTY_W-1:0] main_duty_q, tail_duty_q;
  logic [dpa_pkg::DUTY_W-1:0] main_duty, tail_duty;

  // Register writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= dpa_pkg::RST_UPDATE_RATE;
      duty_ceil_q <= dpa_pkg::RST_DUTY_CEIL;
      main_min_q  <= dpa_pkg::RST_DUTY_FLOOR;
      tail_min_q  <= dpa_pkg::RST_DUTY_FLOOR;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dpa_pkg::REG_UPDATE_RATE: rate_q      <= cfg_i.data[dpa_pkg::RATE_W-1:0];
        dpa_pkg::REG_DUTY_CEIL:   duty_ceil_q <= cfg_i.data[dpa_pkg::DUTY_W-1:0];
        dpa_pkg::REG_MAIN_FLOOR:  main_min_q  <= cfg_i.data[dpa_pkg::DUTY_W-1:0];
        dpa_pkg::REG_TAIL_FLOOR:  tail_min_q  <= cfg_i.data[dpa_pkg::DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A rate of zero behaves as one.
  assign rate_eff = (rate_q == '0) ? dpa_pkg::RATE_W'(1) : rate_q;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = (state_q == dpa_pkg::ST_CLAMP) && (!out_valid_q || out_o.ready);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dpa_pkg::ST_IDLE:  if (in_i.valid) state_d = dpa_pkg::ST_DIV;
      dpa_pkg::ST_DIV:   if (cnt_q == '0) state_d = dpa_pkg::ST_SUM;
      dpa_pkg::ST_SUM:   state_d = dpa_pkg::ST_CLAMP;
      dpa_pkg::ST_CLAMP: if (out_load) state_d = dpa_pkg::ST_IDLE;
      default:           state_d = dpa_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctrl       = '0;
    in_i.ready = 1'b0;
    case (state_q)
      dpa_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        ctrl.start = in_i.valid;
      end
      dpa_pkg::ST_DIV:   ctrl.div_step = 1'b1;
      dpa_pkg::ST_SUM:   ctrl.sum_step = 1'b1;
      dpa_pkg::ST_CLAMP: ctrl.commit   = out_load;
      default: begin
      end
    endcase
  end

  // State register and divider bit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpa_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_q <= CntW'(ERROR_WIDTH - 1);
      end else if (state_q == dpa_pkg::ST_DIV && cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Main rotor lane.
  dpa_lane #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .KP          (dpa_pkg::MAIN_KP),
    .KI          (dpa_pkg::MAIN_KI),
    .KD          (dpa_pkg::MAIN_KD)
  ) u_main_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .err_i   (in_i.alt_error),
    .rate_i  (rate_eff),
    .ceil_i  (duty_ceil_q),
    .floor_i (main_min_q),
    .duty_o  (main_duty)
  );

  // Tail rotor lane.
  dpa_lane #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .KP          (dpa_pkg::TAIL_KP),
    .KI          (dpa_pkg::TAIL_KI),
    .KD          (dpa_pkg::TAIL_KD)
  ) u_tail_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .err_i   (in_i.yaw_error),
    .rate_i  (rate_eff),
    .ceil_i  (duty_ceil_q),
    .floor_i (tail_min_q),
    .duty_o  (tail_duty)
  );

  // Merge both lane duties into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      main_duty_q <= main_duty;
      tail_duty_q <= tail_duty;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.main_duty = main_duty_q;
  assign out_o.tail_duty = tail_duty_q;

endmodule

/* rtl/core/dpa_lane.sv */
module dpa_lane #(
  parameter int ERROR_WIDTH = 16,
  parameter int KP          = 7,
  parameter int KI          = 2,
  parameter int KD          = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dpa_pkg::dpa_ctrl_t              ctrl_i,
  input  logic signed [ERROR_WIDTH-1:0]   err_i,
  input  logic [dpa_pkg::RATE_W-1:0]      rate_i,
  input  logic [dpa_pkg::DUTY_W-1:0]      ceil_i,
  input  logic [dpa_pkg::DUTY_W-1:0]      floor_i,
  output logic [dpa_pkg::DUTY_W-1:0]      duty_o
);

  localparam int DiffW = ERROR_WIDTH + 1;
  localparam int ProdW = DiffW + dpa_pkg::RATE_W + 1;
  localparam int QuotW = ERROR_WIDTH + 1;
  localparam int CandW = dpa_pkg::INTEG_W + 1;
  localparam int SumW  = (((ProdW + 1) > (dpa_pkg::INTEG_W + 2)) ?
                          (ProdW + 1) : (dpa_pkg::INTEG_W + 2)) + 2;
  localparam int RemW  = dpa_pkg::RATE_W;

  localparam logic signed [SumW-1:0] KpS = SumW'(KP);
  localparam logic signed [SumW-1:0] KiS = SumW'(KI);
  localparam logic signed [SumW-1:0] KdS = SumW'(KD);

  localparam logic signed [dpa_pkg::INTEG_W-1:0] IntegMax =
    {1'b0, {(dpa_pkg::INTEG_W-1){1'b1}}};
  localparam logic signed [dpa_pkg::INTEG_W-1:0] IntegMin =
    {1'b1, {(dpa_pkg::INTEG_W-1){1'b0}}};

  // Channel state kept between ticks.
  logic signed [dpa_pkg::INTEG_W-1:0] integ_q;
  logic signed [ERROR_WIDTH-1:0]      last_q;

  // Per-tick working registers.
  logic signed [ERROR_WIDTH-1:0]      err_q;
  logic                               neg_q;
  logic [RemW-1:0]                    rem_q, rem_d;
  logic [ERROR_WIDTH-1:0]             quo_q, quo_d;
  logic signed [ProdW-1:0]            prod_q, prod_d;
  logic signed [dpa_pkg::INTEG_W-1:0] cand_q, cand_d;
  logic signed [SumW-1:0]             pd_q, pd_d;

  logic [ERROR_WIDTH-1:0]             err_mag;
  logic [RemW:0]                      rem_sh;
  logic                               quo_bit;
  logic signed [DiffW-1:0]            diff;
  logic signed [RemW+1:0]             rate_s;
  logic signed [QuotW-1:0]            quot_s;
  logic signed [CandW-1:0]            cand_sum;
  logic signed [SumW-1:0]             sum;
  logic signed [SumW-1:0]             max_ext, min_ext;
  logic                               above, below;

  // Magnitude of the incoming error for the unsigned divider.
  assign err_mag = err_i[ERROR_WIDTH-1] ? (~err_i + 1'b1) : err_i;

  // Restoring divider step: one quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_q, quo_q[ERROR_WIDTH-1]};
    quo_bit = (rem_sh >= {1'b0, rate_i});
    rem_d   = quo_bit ? RemW'(rem_sh - {1'b0, rate_i}) : RemW'(rem_sh);
    quo_d   = {quo_q[ERROR_WIDTH-2:0], quo_bit};
  end

  // Error difference scaled by the update rate.
  always_comb begin
    diff   = DiffW'(err_q) - DiffW'(last_q);
    rate_s = $signed({2'b00, rate_i});
    prod_d = ProdW'(diff) * ProdW'(rate_s);
  end

  // Candidate integral with saturation, plus proportional and derivative terms.
  always_comb begin
    quot_s   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    cand_sum = CandW'(integ_q) + CandW'(quot_s);
    if (cand_sum[CandW-1] != cand_sum[CandW-2]) begin
      cand_d = cand_sum[CandW-1] ? IntegMin : IntegMax;
    end else begin
      cand_d = cand_sum[dpa_pkg::INTEG_W-1:0];
    end
    pd_d = KpS * SumW'(err_q) + KdS * SumW'(prod_q);
  end

  // Final sum and duty clamp.
  always_comb begin
    sum     = pd_q + KiS * SumW'(cand_q);
    max_ext = SumW'($signed({1'b0, ceil_i}));
    min_ext = SumW'($signed({1'b0, floor_i}));
    above   = (sum > max_ext);
    below   = (sum < min_ext);
    if (above) begin
      duty_o = ceil_i;
    end else if (below) begin
      duty_o = floor_i;
    end else begin
      duty_o = sum[dpa_pkg::DUTY_W-1:0];
    end
  end

  // Working registers of the tick in progress.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      err_q <= err_i;
      neg_q <= err_i[ERROR_WIDTH-1];
      quo_q <= err_mag;
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      prod_q <= prod_d;
    end
    if (ctrl_i.sum_step) begin
      cand_q <= cand_d;
      pd_q   <= pd_d;
    end
  end

  // The integral is committed only when the sum lay within the limits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else if (ctrl_i.commit) begin
      last_q <= err_q;
      if (!above && !below) begin
        integ_q <= cand_q;
      end
    end
  end

endmodule

/* rtl/core/dpa_checker.sv */
module dpa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [dpa_pkg::DUTY_W-1:0] main_duty_i,
  input logic [dpa_pkg::DUTY_W-1:0] tail_duty_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Count of ticks taken whose results are not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // Only one tick is worked on at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("second tick taken while the lanes were busy");

  // No result without a tick that caused it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != 2'd0))
    else $error("result delivered without a pending tick");

  // At most one tick in work plus one result waiting.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many ticks outstanding");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(main_duty_i) && $stable(tail_duty_i))
    else $error("stalled result changed");

endmodule

bind dual_pid_antiwindup dpa_checker u_dpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .main_duty_i (out_o.main_duty),
  .tail_duty_i (out_o.tail_duty)
);

/* dv/dual_pid_antiwindup_tb.sv */
`timescale 1ns / 1ps

module dual_pid_antiwindup_tb;

  localparam int ERR_W           = 16;
  localparam int TICK_LATENCY    = ERR_W + 2;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_CYCLES     = 400;
  localparam int N_PHASES        = 16;
  localparam int TICKS_PER_PHASE = 92;
  localparam int N_DIRECTED      = 20;

  // An index outside the register map; a write to it must change nothing.
  localparam logic [dpa_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd12;

  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;

  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    logic [dpa_pkg::DUTY_W-1:0] main_duty;
    logic [dpa_pkg::DUTY_W-1:0] tail_duty;
  } duty_pair_t;

  typedef struct packed {
    logic [dpa_pkg::CFG_IDX_W-1:0]  index;
    logic [dpa_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  // Directed ticks: steady small errors that settle inside the limits, the field
  // extremes, and errors whose division by the rate truncates towards zero.
  localparam err_t DIR_ALT [N_DIRECTED] = '{
    16'sd0, 16'sd5, 16'sd5, 16'sd14, 16'sd14, 16'sh7FFF, 16'sh8000, -16'sd1, -16'sd1,
    16'sd1, 16'sd150, 16'sd150, -16'sd250, -16'sd250, 16'sh5555, 16'shAAAA, 16'sd0,
    16'sd13, 16'sd13, 16'sd13};
  localparam err_t DIR_YAW [N_DIRECTED] = '{
    16'sd0, 16'sd3, 16'sd3, 16'sd9, 16'sd9, 16'sh8000, 16'sh7FFF, -16'sd1, -16'sd1,
    16'sd1, -16'sd150, -16'sd150, 16'sd250, 16'sd250, 16'shAAAA, 16'sh5555, 16'sd0,
    16'sd8, 16'sd8, 16'sd8};

  // Predicts the duty pair of every accepted tick and checks results in order.
  class duty_scoreboard;
    logic [dpa_pkg::RATE_W-1:0] update_rate;
    logic [dpa_pkg::DUTY_W-1:0] duty_ceil;
    logic [dpa_pkg::DUTY_W-1:0] main_floor;
    logic [dpa_pkg::DUTY_W-1:0] tail_floor;
    int                         main_integral;
    int                         tail_integral;
    err_t                       main_last_err;
    err_t                       tail_last_err;
    duty_pair_t                 duty_queue[$];
    int                         mismatches;
    int                         checked;

    function void clear();
      update_rate   = dpa_pkg::RST_UPDATE_RATE;
      duty_ceil     = dpa_pkg::RST_DUTY_CEIL;
      main_floor    = dpa_pkg::RST_DUTY_FLOOR;
      tail_floor    = dpa_pkg::RST_DUTY_FLOOR;
      main_integral = 0;
      tail_integral = 0;
      main_last_err = '0;
      tail_last_err = '0;
      duty_queue.delete();
      mismatches    = 0;
      checked       = 0;
    endfunction

    function void write_register(logic [dpa_pkg::CFG_IDX_W-1:0] idx,
                                 logic [dpa_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        dpa_pkg::REG_UPDATE_RATE: update_rate = val[dpa_pkg::RATE_W-1:0];
        dpa_pkg::REG_DUTY_CEIL:   duty_ceil   = val[dpa_pkg::DUTY_W-1:0];
        dpa_pkg::REG_MAIN_FLOOR:  main_floor  = val[dpa_pkg::DUTY_W-1:0];
        dpa_pkg::REG_TAIL_FLOOR:  tail_floor  = val[dpa_pkg::DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    // One PID lane. A zero rate counts as one. The candidate integral saturates to
    // 32 bits and is kept only when the sum passes both the upper and lower test.
    function logic [dpa_pkg::DUTY_W-1:0] pid_lane_duty(bit is_tail, err_t err);
      longint                     e;
      longint                     rate;
      longint                     integ;
      longint                     last_e;
      longint                     cand;
      longint                     total;
      longint                     hi;
      longint                     lo;
      longint                     kp;
      longint                     ki;
      longint                     kd;
      logic [dpa_pkg::DUTY_W-1:0] duty;
      e      = err;
      rate   = (update_rate == '0) ? 64'sd1 : longint'(update_rate);
      integ  = is_tail ? tail_integral : main_integral;
      last_e = is_tail ? tail_last_err : main_last_err;
      kp     = is_tail ? dpa_pkg::TAIL_KP : dpa_pkg::MAIN_KP;
      ki     = is_tail ? dpa_pkg::TAIL_KI : dpa_pkg::MAIN_KI;
      kd     = is_tail ? dpa_pkg::TAIL_KD : dpa_pkg::MAIN_KD;
      hi     = longint'(duty_ceil);
      lo     = is_tail ? longint'(tail_floor) : longint'(main_floor);

      cand = integ + e / rate;
      if (cand > INTEG_MAX) cand = INTEG_MAX;
      if (cand < INTEG_MIN) cand = INTEG_MIN;
      total = e * kp + cand * ki + (e - last_e) * rate * kd;

      // The upper test comes first, so crossed limits favour the maximum.
      if (total > hi) begin
        duty = duty_ceil;
      end else if (total < lo) begin
        duty = is_tail ? tail_floor : main_floor;
      end else begin
        duty  = total[dpa_pkg::DUTY_W-1:0];
        integ = cand;
      end

      if (is_tail) begin
        tail_integral = int'(integ);
        tail_last_err = err;
      end else begin
        main_integral = int'(integ);
        main_last_err = err;
      end
      return duty;
    endfunction

    function void note_tick(err_t alt, err_t yaw);
      duty_pair_t want;
      want.main_duty = pid_lane_duty(1'b0, alt);
      want.tail_duty = pid_lane_duty(1'b1, yaw);
      duty_queue.push_back(want);
    endfunction

    function void check_duty(logic [dpa_pkg::DUTY_W-1:0] main_d,
                             logic [dpa_pkg::DUTY_W-1:0] tail_d);
      duty_pair_t want;
      if (duty_queue.size() == 0) begin
        $error("Duty result with no tick outstanding: main_duty %0d, tail_duty %0d",
               main_d, tail_d);
        mismatches++;
        return;
      end
      want = duty_queue.pop_front();
      checked++;
      if (main_d !== want.main_duty) begin
        $error("main_duty: expected %0d, actual %0d", want.main_duty, main_d);
        mismatches++;
      end
      if (tail_d !== want.tail_duty) begin
        $error("tail_duty: expected %0d, actual %0d", want.tail_duty, tail_d);
        mismatches++;
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dpa_cfg_if                       cfg_bus ();
  dpa_in_if #(.ERROR_WIDTH(ERR_W)) tick_bus ();
  dpa_out_if                       duty_bus ();

  dual_pid_antiwindup #(
    .ERROR_WIDTH(ERR_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .in_i  (tick_bus),
    .out_o (duty_bus)
  );

  duty_scoreboard sb;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  bit             hold_req       = 1'b0;
  int             cycle_count    = 0;
  int             ticks_sent     = 0;
  int             walk_span      = 60;
  err_t           alt_walk       = '0;
  err_t           yaw_walk       = '0;
  reg_write_t     reg_writes[$];

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Run guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, sb.duty_queue.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Observe every transaction on the three channels at the clock edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (duty_bus.valid && duty_bus.ready) begin
        sb.check_duty(duty_bus.main_duty, duty_bus.tail_duty);
      end
      if (tick_bus.valid && tick_bus.ready) begin
        sb.note_tick(tick_bus.alt_error, tick_bus.yaw_error);
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        sb.write_register(cfg_bus.index, cfg_bus.data);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    duty_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        duty_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        duty_bus.ready <= !roll(recv_stall_pct);
      end
    end
  end

  // Offer one tick, after an optional idle gap, and wait for its transaction.
  // Valid stays high afterwards so that back-to-back ticks need no gap.
  task automatic send_tick(err_t alt, err_t yaw);
    if (roll(send_idle_pct)) begin
      tick_bus.valid <= 1'b0;
      @(posedge clk);
      while (roll(send_idle_pct)) @(posedge clk);
    end
    tick_bus.valid     <= 1'b1;
    tick_bus.alt_error <= alt;
    tick_bus.yaw_error <= yaw;
    @(posedge clk);
    while (!tick_bus.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Stop offering ticks and let every outstanding result come back.
  task automatic wait_idle();
    tick_bus.valid <= 1'b0;
    while (sb.duty_queue.size() != 0) @(posedge clk);
    repeat (TICK_LATENCY + 2) @(posedge clk);
  endtask

  task automatic flush_reg_writes();
    reg_write_t wr;
    while (reg_writes.size() != 0) begin
      wr = reg_writes.pop_front();
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= wr.index;
      cfg_bus.data  <= wr.data;
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic void set_limits(int rate, int maxd, int mmin, int tmin);
    reg_writes.push_back(reg_write_t'{index: dpa_pkg::REG_UPDATE_RATE,
                                      data: dpa_pkg::CFG_DATA_W'(rate)});
    reg_writes.push_back(reg_write_t'{index: dpa_pkg::REG_DUTY_CEIL,
                                      data: dpa_pkg::CFG_DATA_W'(maxd)});
    reg_writes.push_back(reg_write_t'{index: dpa_pkg::REG_MAIN_FLOOR,
                                      data: dpa_pkg::CFG_DATA_W'(mmin)});
    reg_writes.push_back(reg_write_t'{index: dpa_pkg::REG_TAIL_FLOOR,
                                      data: dpa_pkg::CFG_DATA_W'(tmin)});
  endfunction

  // Error sequences mostly drift slowly within a window, so that the derivative
  // stays small and sums land between the limits; the rest is noise and extremes.
  function automatic err_t next_error(err_t prev, int span);
    int pick;
    int stepped;
    pick = $urandom_range(99);
    if (pick < 10) return err_t'($urandom);
    if (pick < 14) begin
      case ($urandom_range(3))
        0:       return {1'b0, {(ERR_W-1){1'b1}}};
        1:       return {1'b1, {(ERR_W-1){1'b0}}};
        2:       return '1;
        default: return '0;
      endcase
    end
    stepped = int'(prev);
    if (pick >= 55) stepped += int'($urandom_range(6)) - 3;
    if (stepped > span) stepped = span;
    if (stepped < -span) stepped = -span;
    return err_t'(stepped);
  endfunction

  // Main sequence: reset, directed ticks, then phases of register settings.
  initial begin
    int rate_v;
    int maxd_v;
    int mmin_v;
    int tmin_v;
    sb = new;
    sb.clear();
    tick_bus.valid     <= 1'b0;
    tick_bus.alt_error <= '0;
    tick_bus.yaw_error <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= dpa_pkg::REG_UPDATE_RATE;
    cfg_bus.data       <= '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks at the settings left by reset.
    for (int i = 0; i < N_DIRECTED; i++) send_tick(DIR_ALT[i], DIR_YAW[i]);
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      // Fixed corners first: zero rate, rates near and at the top of the range,
      // maximum duty at both ends, and minimums above the maximum.
      case (p)
        0: set_limits(1, 100, 0, 0);
        1: set_limits(1000, 100, 2, 2);
        2: set_limits(0, 127, 0, 0);
        3: set_limits(1023, 98, 10, 20);
        4: set_limits(5, 40, 60, 50);
        5: set_limits(10, 0, 0, 0);
        6: set_limits(3, 127, 127, 127);
        7: set_limits(100, 98, 2, 2);
        default: begin
          rate_v = roll(50) ? $urandom_range(1, 20) : $urandom_range(0, 1023);
          maxd_v = roll(25) ? $urandom_range(0, 1023) : $urandom_range(40, 110);
          mmin_v = roll(25) ? $urandom_range(0, 1023) : $urandom_range(0, 20);
          tmin_v = roll(25) ? $urandom_range(0, 1023) : $urandom_range(0, 20);
          set_limits(rate_v, maxd_v, mmin_v, tmin_v);
        end
      endcase
      if (p == 9) begin
        reg_writes.push_back(reg_write_t'{index: REG_SPARE, data: '1});
      end
      flush_reg_writes();

      // Idling pattern for this phase.
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      walk_span = (p % 3 == 2) ? 600 : 60;

      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        // Hold the result side off while ticks keep coming, to back up the input.
        if (p == 4 && i == 20) hold_req = 1'b1;
        alt_walk = next_error(alt_walk, walk_span);
        yaw_walk = next_error(yaw_walk, walk_span);
        send_tick(alt_walk, yaw_walk);
      end
      wait_idle();
    end

    $display("Sent %0d control ticks (%0d directed) across %0d register settings,",
             ticks_sent, N_DIRECTED, N_PHASES + 1);
    $display("with four stall patterns and one long result hold-off; %0d results checked.",
             sb.checked);
    if (sb.mismatches == 0 && sb.duty_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/dpa_pkg.sv
rtl/core/dpa_if.sv
rtl/core/dpa_lane.sv
rtl/core/dual_pid_antiwindup.sv
rtl/core/dpa_checker.sv
dv/dual_pid_antiwindup_tb.sv
